// ===== hw/rtl/sawlc_pkg.sv =====
// Package with the cache geometry, request and result types and result codes.
package sawlc_pkg;
    localparam int NUM_SETS    = 64;
    localparam int NUM_WAYS    = 4;
    localparam int BLOCK_BYTES = 32;
    localparam int AGE_BITS    = 8;

    localparam int WORDS      = BLOCK_BYTES / 4;
    localparam int OFF_BITS   = $clog2(BLOCK_BYTES);
    localparam int SET_BITS   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SET_USE    = $clog2(NUM_SETS);
    localparam int TAG_BITS   = 32 - OFF_BITS - SET_USE;
    localparam int WAY_BITS   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int WORD_BITS  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_BITS   = $clog2(WORDS + 1);
    localparam int LINE_BITS  = SET_BITS + WAY_BITS;
    localparam int DADDR_BITS = LINE_BITS + WORD_BITS;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_STORE  = 2'd1;
    localparam logic [1:0] FUNC_FILL   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [2:0] KIND_LOAD   = 3'd0;
    localparam logic [2:0] KIND_STORE  = 3'd1;
    localparam logic [2:0] KIND_WB     = 3'd2;
    localparam logic [2:0] KIND_FILLRQ = 3'd3;
    localparam logic [2:0] KIND_REJECT = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] address;
        logic [31:0] data;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] mem_address;
        logic [31:0] word_out;
        logic        miss;
        logic        last;
    } t_res;

    // One line's metadata; a set holds NUM_WAYS of these in one memory row.
    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [TAG_BITS-1:0] tag;
        logic [AGE_BITS-1:0] age;
    } t_line;

    typedef t_line [NUM_WAYS-1:0] t_set_row;

    function automatic logic [SET_BITS-1:0] set_of(input logic [31:0] a);
        logic [31:0] s;
        s = a >> OFF_BITS;
        return (NUM_SETS > 1) ? s[SET_BITS-1:0] : '0;
    endfunction

    function automatic logic [TAG_BITS-1:0] tag_of(input logic [31:0] a);
        logic [31:0] t;
        t = a >> (OFF_BITS + SET_USE);
        return t[TAG_BITS-1:0];
    endfunction

    function automatic logic [WORD_BITS-1:0] word_of(input logic [31:0] a);
        logic [31:0] w;
        w = (a & 32'(BLOCK_BYTES - 1)) >> 2;
        return (WORDS > 1) ? w[WORD_BITS-1:0] : '0;
    endfunction
endpackage

// ===== hw/rtl/sawlc_tag_ram.sv =====
// Metadata memory: one row per set holding every way's valid, dirty, tag and age.
module sawlc_tag_ram
    import sawlc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [SET_BITS-1:0] i_waddr,
    input  t_set_row            i_wdata,
    input  logic [SET_BITS-1:0] i_raddr,
    output t_set_row            o_rdata
);
    t_set_row mem [NUM_SETS];

    // Synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== hw/rtl/sawlc_data_ram.sv =====
// Block data memory: one 32-bit word per entry, one write and one read port.
module sawlc_data_ram
    import sawlc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [DADDR_BITS-1:0] i_waddr,
    input  logic [31:0]           i_wdata,
    input  logic [DADDR_BITS-1:0] i_raddr,
    output logic [31:0]           o_rdata
);
    logic [31:0] mem [2**DADDR_BITS];

    // Synchronous write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== hw/rtl/set_assoc_writeback_lru_cache_unit.sv =====
// Top level of the set-associative write-back LRU cache with its controller.
//
// Requests enter on i_req when i_start is high and o_busy is low. Each request
// is a load, a store, or a fill word returned by memory. Results leave on o_res
// with o_strobe high for one cycle; the receiver cannot stall them, and the
// result with last set closes the request.
// A load or store hit passes through S_TAG, which reads the metadata row of
// the set, S_LOOK, which reads the data word, and S_DONE, which forms the
// result while the updated ages are written back.
// A miss first shows any dirty victim's words one per cycle (one result per
// data memory read), then the fill request; the access completes on the last
// fill word, which passes through S_FILLW and S_FILLD. Fill words before the
// last are written in S_FILLW and give no result; rejects answer from S_IDLE.
// Requests are handled one at a time: o_busy holds off a new one until the
// controller is back in S_IDLE, and a dirty eviction adds the S_WB pass.
// At reset the metadata memory is cleared by a pass over all NUM_SETS rows,
// one per cycle; o_busy stays high during the pass. Data words that
// were never written read as undefined but are never shown before a fill.
module set_assoc_writeback_lru_cache_unit
    import sawlc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_strobe,
    output t_res o_res
);
    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_TAG   = 8'b0000_0100,
        S_LOOK  = 8'b0000_1000,
        S_WB    = 8'b0001_0000,
        S_DONE  = 8'b0010_0000,
        S_FILLW = 8'b0100_0000,
        S_FILLD = 8'b1000_0000
    } t_state;

    t_state                r_state, n_state;
    t_req                  r_req, n_req;
    logic [SET_BITS:0]     r_clr, n_clr;
    t_set_row              r_row, n_row;
    logic [WAY_BITS-1:0]   r_way, n_way;
    logic                  r_hit, n_hit;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [TAG_BITS-1:0]   r_vtag, n_vtag;
    logic                  r_pend, n_pend;
    logic [1:0]            r_pfunc, n_pfunc;
    logic [WAY_BITS-1:0]   r_pway, n_pway;
    logic [31:0]           r_paddr, n_paddr;
    logic [31:0]           r_pval, n_pval;
    logic [CNT_BITS-1:0]   r_fcnt, n_fcnt;
    logic                  r_strobe, n_strobe;
    t_res                  r_res, n_res;
    logic                  r_fwd;
    logic [31:0]           r_fwd_data;

    logic                  tag_we;
    logic [SET_BITS-1:0]   tag_waddr, tag_raddr;
    t_set_row              tag_wdata, tag_rdata;
    logic                  dat_we;
    logic [DADDR_BITS-1:0] dat_waddr, dat_raddr;
    logic [31:0]           dat_wdata, dat_rdata;

    sawlc_tag_ram u_tag (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(tag_waddr), .i_wdata(tag_wdata),
        .i_raddr(tag_raddr), .o_rdata(tag_rdata)
    );

    sawlc_data_ram u_data (
        .i_clk(i_clk), .i_we(dat_we), .i_waddr(dat_waddr), .i_wdata(dat_wdata),
        .i_raddr(dat_raddr), .o_rdata(dat_rdata)
    );

    function automatic logic [DADDR_BITS-1:0] daddr(input logic [SET_BITS-1:0] s,
                                                   input logic [WAY_BITS-1:0] w,
                                                   input logic [WORD_BITS-1:0] o);
        logic [LINE_BITS-1:0] ln;
        ln = (LINE_BITS'(s) * LINE_BITS'(NUM_WAYS)) + LINE_BITS'(w);
        return (DADDR_BITS'(ln) * DADDR_BITS'(WORDS)) + DADDR_BITS'(o);
    endfunction

    function automatic logic [AGE_BITS-1:0] age_inc(input logic [AGE_BITS-1:0] a);
        return (&a) ? a : a + 1'b1;
    endfunction

    logic [SET_BITS-1:0]  cur_set;
    logic [TAG_BITS-1:0]  cur_tag;
    logic [WORD_BITS-1:0] cur_word;
    logic                 hit_any;
    logic [WAY_BITS-1:0]  hit_way, vict_way;
    t_set_row             aged_row;
    logic [31:0]          vbase;

    assign cur_set  = set_of(r_req.address);
    assign cur_tag  = tag_of(r_req.address);
    assign cur_word = word_of(r_req.address);

    // Hit search, aging and victim choice over the row just read.
    always_comb begin
        logic [AGE_BITS-1:0] best;
        hit_any  = 1'b0;
        hit_way  = '0;
        vict_way = '0;
        for (int i = 0; i < NUM_WAYS; i++) begin
            aged_row[i]     = tag_rdata[i];
            aged_row[i].age = age_inc(tag_rdata[i].age);
            if (!hit_any && tag_rdata[i].valid && tag_rdata[i].tag == cur_tag) begin
                hit_any = 1'b1;
                hit_way = WAY_BITS'(i);
            end
        end
        best = aged_row[0].age;
        for (int i = 1; i < NUM_WAYS; i++) begin
            if (aged_row[i].age > best) begin
                best     = aged_row[i].age;
                vict_way = WAY_BITS'(i);
            end
        end
    end

    assign vbase = {r_vtag, cur_set, OFF_BITS'(0)};

    // Controller next state.
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_clr    = r_clr;
        n_row    = r_row;
        n_way    = r_way;
        n_hit    = r_hit;
        n_cnt    = r_cnt;
        n_vtag   = r_vtag;
        n_pend   = r_pend;
        n_pfunc  = r_pfunc;
        n_pway   = r_pway;
        n_paddr  = r_paddr;
        n_pval   = r_pval;
        n_fcnt   = r_fcnt;
        n_strobe = 1'b0;
        n_res    = '0;
        tag_we    = 1'b0;
        tag_waddr = cur_set;
        tag_wdata = r_row;
        tag_raddr = cur_set;
        dat_we    = 1'b0;
        dat_waddr = daddr(cur_set, r_way, cur_word);
        dat_wdata = r_req.data;
        dat_raddr = daddr(cur_set, r_way, cur_word);

        case (r_state)
            S_CLEAR: begin
                tag_we    = 1'b1;
                tag_waddr = r_clr[SET_BITS-1:0];
                tag_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == (SET_BITS+1)'(NUM_SETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req;
                    if (i_req.func == FUNC_FILL) begin
                        if (r_pend) begin
                            n_state = S_FILLW;
                        end else begin
                            n_strobe = 1'b1;
                            n_res    = '{KIND_REJECT, 32'd0, 32'd0, 1'b0, 1'b1};
                        end
                    end else if (i_req.func == FUNC_UNUSED || r_pend) begin
                        n_strobe = 1'b1;
                        n_res    = '{KIND_REJECT, 32'd0, 32'd0, 1'b0, 1'b1};
                    end else begin
                        n_state = S_TAG;
                    end
                end
            end
            S_TAG: begin
                // Row read is in flight; issue nothing else.
                n_state = S_LOOK;
            end
            S_LOOK: begin
                n_row = aged_row;
                if (hit_any) begin
                    n_hit = 1'b1;
                    n_way = hit_way;
                    n_row[hit_way].age = '0;
                    if (r_req.func == FUNC_STORE) begin
                        n_row[hit_way].dirty = 1'b1;
                    end
                    dat_raddr = daddr(cur_set, hit_way, cur_word);
                    n_state   = S_DONE;
                end else begin
                    n_hit  = 1'b0;
                    n_way  = vict_way;
                    n_vtag = tag_rdata[vict_way].tag;
                    n_cnt  = '0;
                    n_row[vict_way] = '{1'b0, 1'b0, cur_tag, {AGE_BITS{1'b0}}};
                    dat_raddr = daddr(cur_set, vict_way, '0);
                    if (tag_rdata[vict_way].valid && tag_rdata[vict_way].dirty) begin
                        n_state = S_WB;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WB: begin
                // One victim word per cycle, each read in the cycle before it is shown.
                n_strobe = 1'b1;
                n_res = '{KIND_WB,
                          vbase + 32'({r_cnt[WORD_BITS-1:0] & WORD_BITS'(WORDS - 1),
                                       2'b00}),
                          dat_rdata, 1'b0, 1'b0};
                n_cnt     = r_cnt + 1'b1;
                dat_raddr = daddr(cur_set, r_way, WORD_BITS'(r_cnt + 1'b1));
                if (r_cnt == CNT_BITS'(WORDS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                tag_we   = 1'b1;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                if (r_hit) begin
                    if (r_req.func == FUNC_LOAD) begin
                        n_res = '{KIND_LOAD, 32'd0, dat_rdata, 1'b0, 1'b1};
                    end else begin
                        dat_we = 1'b1;
                        n_res  = '{KIND_STORE, 32'd0, 32'd0, 1'b0, 1'b1};
                    end
                end else begin
                    n_res = '{KIND_FILLRQ, r_req.address & ~32'(BLOCK_BYTES - 1),
                              32'd0, 1'b0, 1'b1};
                    n_pend  = 1'b1;
                    n_pfunc = r_req.func;
                    n_pway  = r_way;
                    n_paddr = r_req.address;
                    n_pval  = r_req.data;
                    n_fcnt  = '0;
                end
            end
            S_FILLW: begin
                dat_we    = 1'b1;
                dat_waddr = daddr(set_of(r_paddr), r_pway, WORD_BITS'(r_fcnt));
                dat_wdata = r_req.data;
                tag_raddr = set_of(r_paddr);
                n_fcnt    = r_fcnt + 1'b1;
                if (r_fcnt == CNT_BITS'(WORDS - 1)) begin
                    n_state = S_FILLD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FILLD: begin
                // Row and requested word are read; validate and finish.
                tag_waddr = set_of(r_paddr);
                tag_wdata = tag_rdata;
                tag_wdata[r_pway].valid = 1'b1;
                n_strobe = 1'b1;
                n_pend   = 1'b0;
                n_fcnt   = '0;
                n_state  = S_IDLE;
                tag_we   = 1'b1;
                if (r_pfunc == FUNC_LOAD) begin
                    n_res = '{KIND_LOAD, 32'd0, r_fwd ? r_fwd_data : dat_rdata,
                              1'b1, 1'b1};
                end else begin
                    tag_wdata[r_pway].dirty = 1'b1;
                    dat_we    = 1'b1;
                    dat_waddr = daddr(set_of(r_paddr), r_pway, word_of(r_paddr));
                    dat_wdata = r_pval;
                    n_res     = '{KIND_STORE, 32'd0, 32'd0, 1'b1, 1'b1};
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The last fill word is written while the requested word is read.
        if (r_state == S_FILLW) begin
            dat_raddr = daddr(set_of(r_paddr), r_pway, word_of(r_paddr));
        end
    end

    // Forward the last fill word when it is the word being read back.
    always_ff @(posedge i_clk) begin
        r_fwd      <= dat_we && (dat_waddr == dat_raddr);
        r_fwd_data <= dat_wdata;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pend   <= 1'b0;
            r_fcnt   <= '0;
            r_strobe <= 1'b0;
            r_pfunc  <= '0;
            r_pway   <= '0;
            r_paddr  <= '0;
            r_pval   <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pend   <= n_pend;
            r_fcnt   <= n_fcnt;
            r_strobe <= n_strobe;
            r_pfunc  <= n_pfunc;
            r_pway   <= n_pway;
            r_paddr  <= n_paddr;
            r_pval   <= n_pval;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_row  <= n_row;
        r_way  <= n_way;
        r_hit  <= n_hit;
        r_cnt  <= n_cnt;
        r_vtag <= n_vtag;
        r_res  <= n_res;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // Results only appear while a request is in progress or just finished.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) != S_IDLE || $past(i_start))
        else $error("result without a request");
    a_no_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |=> !o_strobe)
        else $error("result during clearing pass");
    a_pend_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.miss) |-> $past(r_state) == S_FILLD)
        else $error("miss flag outside fill completion");
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the set-associative write-back LRU cache unit.
module tb_top;
    import sawlc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINES = NUM_SETS * NUM_WAYS;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_req i_req = '0;
    logic o_busy;
    logic o_strobe;
    t_res o_res;

    set_assoc_writeback_lru_cache_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_req(i_req),
        .o_busy(o_busy), .o_strobe(o_strobe), .o_res(o_res)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the cache contents.
    logic                cv_valid [LINES];
    logic                cv_dirty [LINES];
    logic [TAG_BITS-1:0] cv_tag [LINES];
    logic [AGE_BITS-1:0] cv_age [LINES];
    logic [31:0]         cv_word [LINES * WORDS];
    logic                fill_busy = 1'b0;
    logic [1:0]          fill_func = '0;
    int                  fill_way = 0;
    logic [31:0]         fill_addr = '0;
    logic [31:0]         fill_store = '0;
    int                  fill_cnt = 0;

    t_req  pending_reqs[$];
    t_res  expected_res[$];
    int    fail_count = 0;
    int    accepted = 0;
    int    checked = 0;
    int    miss_count = 0;
    logic  idle_on = 1'b1;

    function automatic t_res mk_res(logic [2:0] k, logic [31:0] a, logic [31:0] w,
                                    logic m, logic l);
        t_res r;
        r.kind = k; r.mem_address = a; r.word_out = w; r.miss = m; r.last = l;
        return r;
    endfunction

    function automatic void age_bump(int ln);
        if (cv_age[ln] != '1) cv_age[ln] = cv_age[ln] + 1'b1;
    endfunction

    // Computes the results one accepted request causes and updates the shadow.
    function automatic void predict_cache(t_req q);
        int set_i, first, wi, ln, vict, base;
        logic [TAG_BITS-1:0] tg;
        logic [31:0] old_base;
        if (q.func == FUNC_FILL) begin
            if (!fill_busy || fill_cnt >= WORDS) begin
                expected_res.push_back(mk_res(KIND_REJECT, 0, 0, 0, 1));
                return;
            end
            ln = int'((fill_addr >> OFF_BITS) % NUM_SETS) * NUM_WAYS + fill_way;
            base = ln * WORDS;
            cv_word[base + fill_cnt] = q.data;
            fill_cnt++;
            if (fill_cnt < WORDS) return;
            fill_busy = 0;
            fill_cnt = 0;
            cv_valid[ln] = 1;
            wi = int'((fill_addr % BLOCK_BYTES) >> 2);
            miss_count++;
            if (fill_func == FUNC_LOAD) begin
                expected_res.push_back(mk_res(KIND_LOAD, 0, cv_word[base + wi], 1, 1));
            end else begin
                cv_word[base + wi] = fill_store;
                cv_dirty[ln] = 1;
                expected_res.push_back(mk_res(KIND_STORE, 0, 0, 1, 1));
            end
            return;
        end
        if (q.func == FUNC_UNUSED || fill_busy) begin
            expected_res.push_back(mk_res(KIND_REJECT, 0, 0, 0, 1));
            return;
        end
        set_i = int'((q.address >> OFF_BITS) % NUM_SETS);
        tg = TAG_BITS'(q.address >> (OFF_BITS + SET_USE));
        first = set_i * NUM_WAYS;
        wi = int'((q.address % BLOCK_BYTES) >> 2);
        // Hit path.
        for (int i = 0; i < NUM_WAYS; i++) begin
            ln = first + i;
            if (cv_valid[ln] && cv_tag[ln] == tg) begin
                for (int j = 0; j < NUM_WAYS; j++) age_bump(first + j);
                cv_age[ln] = 0;
                if (q.func == FUNC_LOAD) begin
                    expected_res.push_back(mk_res(KIND_LOAD, 0, cv_word[ln*WORDS + wi], 0, 1));
                end else begin
                    cv_word[ln*WORDS + wi] = q.data;
                    cv_dirty[ln] = 1;
                    expected_res.push_back(mk_res(KIND_STORE, 0, 0, 0, 1));
                end
                return;
            end
        end
        // Miss: age the set, pick the oldest way, lowest on ties.
        for (int i = 0; i < NUM_WAYS; i++) age_bump(first + i);
        vict = 0;
        for (int i = 1; i < NUM_WAYS; i++)
            if (cv_age[first + i] > cv_age[first + vict]) vict = i;
        ln = first + vict;
        if (cv_valid[ln] && cv_dirty[ln]) begin
            old_base = 32'((longint'(cv_tag[ln]) * NUM_SETS + set_i) * BLOCK_BYTES);
            for (int i = 0; i < WORDS; i++)
                expected_res.push_back(mk_res(KIND_WB, old_base + 32'(i << 2),
                                              cv_word[ln*WORDS + i], 0, 0));
        end
        cv_valid[ln] = 0;
        cv_dirty[ln] = 0;
        cv_age[ln] = 0;
        cv_tag[ln] = tg;
        fill_busy = 1;
        fill_cnt = 0;
        fill_func = q.func;
        fill_way = vict;
        fill_addr = q.address;
        fill_store = q.data;
        expected_res.push_back(mk_res(KIND_FILLRQ, q.address - (q.address % BLOCK_BYTES),
                                      0, 0, 1));
    endfunction

    // Driver: presents queued requests, idling at random.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                predict_cache(i_req);
                accepted++;
            end
            if (!(i_start && o_busy)) begin
                if (pending_reqs.size() > 0 && (!idle_on || $urandom_range(99) >= 38))
                begin
                    i_req <= pending_reqs.pop_front();
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each strobed result with the oldest expectation.
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_strobe) begin
            if (expected_res.size() == 0) begin
                $error("unexpected result kind=%0d", o_res.kind);
                fail_count++;
            end else begin
                e = expected_res.pop_front();
                checked++;
                if (o_res.kind !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, o_res.kind); fail_count++;
                end
                if (o_res.mem_address !== e.mem_address) begin
                    $error("mem_address exp %h got %h", e.mem_address, o_res.mem_address);
                    fail_count++;
                end
                if (o_res.word_out !== e.word_out) begin
                    $error("word_out exp %h got %h", e.word_out, o_res.word_out);
                    fail_count++;
                end
                if (o_res.miss !== e.miss) begin
                    $error("miss exp %0d got %0d", e.miss, o_res.miss); fail_count++;
                end
                if (o_res.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_res.last); fail_count++;
                end
            end
        end
    end

    function automatic t_req mk_req(logic [1:0] f, logic [31:0] a, logic [31:0] d);
        t_req q;
        q.func = f; q.address = a; q.data = d;
        return q;
    endfunction

    // Queues one access followed by the fill words it may need.
    function automatic void push_access(logic [1:0] f, logic [31:0] a, logic [31:0] d);
        pending_reqs.push_back(mk_req(f, a, d));
        for (int i = 0; i < WORDS; i++)
            pending_reqs.push_back(mk_req(FUNC_FILL, $urandom, $urandom));
    endfunction

    // Addresses from a few tags so that sets collide and evict.
    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        a = (32'($urandom_range(5)) << (OFF_BITS + SET_USE))
            | (32'($urandom_range(3)) << OFF_BITS);
        a[4:0] = 5'($urandom);
        if ($urandom_range(9) == 0) a = $urandom;
        return a;
    endfunction

    initial begin
        int n;
        logic stalled;
        for (int i = 0; i < LINES; i++) begin
            cv_valid[i] = 0; cv_dirty[i] = 0; cv_tag[i] = '0; cv_age[i] = '0;
        end
        for (int i = 0; i < LINES * WORDS; i++) cv_word[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: rejects, extremes, miss, hit, dirty eviction.
        pending_reqs.push_back(mk_req(FUNC_FILL, 32'h0, 32'hFFFF_FFFF));
        pending_reqs.push_back(mk_req(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        push_access(FUNC_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        pending_reqs.push_back(mk_req(FUNC_LOAD, 32'hFFFF_FFFC, 0));
        pending_reqs.push_back(mk_req(FUNC_LOAD, 32'h0, 0));
        pending_reqs.push_back(mk_req(FUNC_STORE, 32'h0, 0));
        for (int i = 0; i < WORDS; i++)
            pending_reqs.push_back(mk_req(FUNC_FILL, 0, 32'(i)));
        pending_reqs.push_back(mk_req(FUNC_FILL, 0, 0));
        for (int t = 1; t <= 4; t++)
            push_access(FUNC_LOAD, 32'hFFFF_FFE0 - 32'(t) * 32'h800, 0);
        while (pending_reqs.size() > 0 || expected_res.size() > 0) @(posedge i_clk);

        // Random part, counted in requests; idling is disabled for a stretch in the middle.
        n = 0;
        stalled = 1'b0;
        while (n < 220) begin
            if (!stalled && n >= 100) begin
                while (pending_reqs.size() > 0 || i_start || expected_res.size() > 0)
                    @(posedge i_clk);
                idle_on = 1'b0;
                stalled = 1'b1;
            end
            if (n >= 160) idle_on = 1'b1;
            if ($urandom_range(9) < 8) begin
                push_access({1'b0, 1'($urandom)}, pick_addr(), $urandom);
                n += 1 + WORDS;
            end else begin
                pending_reqs.push_back(mk_req(2'($urandom), $urandom, $urandom));
                n++;
            end
            while (pending_reqs.size() > 20) @(posedge i_clk);
        end
        while (pending_reqs.size() > 0 || i_start || expected_res.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Accepted %0d requests, checked %0d results, %0d misses completed.",
                 accepted, checked, miss_count);
        if (fail_count == 0 && expected_res.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end
endmodule

// ===== set_assoc_writeback_lru_cache_unit.f =====
hw/rtl/sawlc_pkg.sv
hw/rtl/sawlc_tag_ram.sv
hw/rtl/sawlc_data_ram.sv
hw/rtl/set_assoc_writeback_lru_cache_unit.sv
verif/tb_top.sv
